[sv/tcrg_pkg.sv]
// tcrg_pkg.sv: shared types, constants and tables of the tempo clock ratio gates block
`default_nettype none
package tcrg_pkg;

    localparam int BPM_W      = 9;
    localparam int SEL_W      = 5;
    localparam int PPQN_SEL_W = 3;
    localparam int SR_W       = 18;
    localparam int PLEN_W     = 11;
    localparam int PLEFT_W    = 10;
    localparam int SE_W       = 32;
    localparam int PPQN_W     = 5;
    localparam int DEN_W      = SE_W + PPQN_W;
    localparam int RATIO_W    = 6;
    localparam int WARM_W     = 2;
    localparam int NUM_CH     = 3;
    localparam int NUM_ACC    = 4;
    localparam int NUM_SEL    = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [BPM_W-1:0]      BPM_MIN       = 9'd15;
    localparam logic [BPM_W-1:0]      BPM_MAX       = 9'd300;
    localparam logic [BPM_W-1:0]      BPM_RST       = 9'd120;
    localparam logic [SR_W-1:0]       SR_MIN        = 18'd8000;
    localparam logic [SR_W-1:0]       SR_MAX        = 18'd192000;
    localparam logic [SR_W-1:0]       SR_RST        = 18'd48000;
    localparam logic [PLEN_W-1:0]     PLEN_MIN      = 11'd1;
    localparam logic [PLEN_W-1:0]     PLEN_MAX      = 11'd1024;
    localparam logic [PLEN_W-1:0]     PLEN_RST      = 11'd48;
    localparam logic [SEL_W-1:0]      SEL_MAX       = 5'd22;
    localparam logic [SEL_W-1:0]      SEL_RST       = 5'd11;
    localparam logic [SEL_W-1:0]      MUL_SEL_FIRST = 5'd11;
    localparam logic [PPQN_SEL_W-1:0] PPQN_SEL_RST  = 3'd0;
    localparam logic [WARM_W-1:0]     WARM_DONE     = 2'd2;
    localparam logic [SE_W-1:0]       SE_SAT        = '1;
    localparam logic [DEN_W-1:0]      SEC_PER_MIN   = 37'd60;
    localparam logic                  RUN_RST       = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_ONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_TWO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THREE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PPQN         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_AT_RESET = 3'd7;

    localparam logic [RATIO_W-1:0] RATIO_TAB [NUM_SEL] = '{
        6'd48, 6'd32, 6'd24, 6'd16, 6'd12, 6'd8, 6'd6, 6'd5, 6'd4, 6'd3, 6'd2, 6'd1,
        6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd8, 6'd12, 6'd16, 6'd24, 6'd32, 6'd48
    };

    typedef struct packed {
        logic reset_level;
        logic run_toggle_level;
        logic ext_clock_level;
        logic ext_connected;
    } t_in;

    typedef struct packed {
        logic master_gate;
        logic gate_one;
        logic gate_two;
        logic gate_three;
        logic running;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRONT,
        S_MDIV,
        S_LATCH,
        S_CHAN,
        S_CDIV,
        S_ADVANCE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_item;
        logic front;
        logic master_take;
        logic latch;
        logic chan_eval;
        logic chan_take;
        logic advance;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic run;
        logic div_done;
        logic chan_mul;
        logic chan_last;
        logic out_free;
    } t_sts;

    function automatic logic [SEL_W-1:0] clamp_sel(input logic [SEL_W-1:0] sel);
        return (sel > SEL_MAX) ? SEL_MAX : sel;
    endfunction

    function automatic logic [PPQN_W-1:0] ppqn_of(input logic [PPQN_SEL_W-1:0] sel);
        logic [PPQN_W-1:0] val;
        unique case (sel)
            3'd0:    val = 5'd2;
            3'd1:    val = 5'd4;
            3'd2:    val = 5'd8;
            3'd3:    val = 5'd12;
            default: val = 5'd24;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

[sv/tcrg_div.sv]
// tcrg_div.sv: shared restoring divider, one quotient bit per cycle
`default_nettype none
module tcrg_div
    import tcrg_pkg::*;
#(
    parameter int NUM_W  = 41,
    parameter int D_W    = 37,
    parameter int STEP_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [D_W-1:0]    i_den,
    input  wire logic [STEP_W-1:0] i_steps,
    output logic                   o_busy,
    output logic [NUM_W-1:0]       o_quot
);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [D_W-1:0]    r_den;
    logic [D_W-1:0]    r_rem;
    logic [NUM_W-1:0]  r_quot;

    logic [D_W:0]      rem_sh;
    logic              ge;
    logic [D_W:0]      rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_steps != '0);
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - STEP_W'(1);
            r_busy <= (r_cnt != STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

[sv/tcrg_dp.sv]
// tcrg_dp.sv: datapath with configuration, phase accumulators, sync logic and gate pulses
`default_nettype none
module tcrg_dp
    import tcrg_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TIMEOUT_SECONDS = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_in                   i_in_data,
    input  wire t_cmd                  i_cmd,
    input  wire logic                  i_out_ready,
    output t_sts                       o_sts,
    output logic                       o_out_valid,
    output t_out                       o_out_data
);

    localparam int NUM_W  = PHASE_BITS + BPM_W;
    localparam int INC_W  = PHASE_BITS + RATIO_W;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [PHASE_BITS-1:0] SYNC_INC_RST = PHASE_BITS'(
        (64'(BPM_RST) << PHASE_BITS) / (64'd60 * 64'(SR_RST)));

    // configuration
    logic [BPM_W-1:0]      r_tempo;
    logic [SEL_W-1:0]      r_sel [NUM_CH];
    logic [PPQN_SEL_W-1:0] r_ppqn_sel;
    logic [SR_W-1:0]       r_sr;
    logic [PLEN_W-1:0]     r_plen;

    // item state
    t_in                   r_item;
    logic [2:0]            r_prev;
    logic                  r_run_latch;
    logic [SE_W-1:0]       r_since;
    logic [WARM_W-1:0]     r_warm;
    logic [PHASE_BITS-1:0] r_sync_inc;
    logic [SEL_W-1:0]      r_lsel [NUM_CH];
    logic [PHASE_BITS-1:0] r_phase [NUM_ACC];
    logic [PLEFT_W-1:0]    r_pleft [NUM_ACC];
    logic                  r_run;
    logic [INC_W-1:0]      r_inc_ch [NUM_CH];
    logic [1:0]            r_k;
    t_out                  r_res;
    logic                  r_out_valid;
    t_out                  r_out_data;

    logic [BPM_W-1:0]      tempo_c;
    logic [SR_W-1:0]       sr_c;
    logic [PLEN_W-1:0]     plen_c;

    logic                  rst_edge;
    logic                  tog_edge;
    logic                  clk_edge;
    logic                  run_latch_nx;
    logic [SE_W-1:0]       se_inc;
    logic [SE_W-1:0]       to_lim;
    logic                  timed;
    logic                  sync_div;
    logic                  need_div;
    logic                  f_run;
    logic [DEN_W-1:0]      sync_den;
    logic [DEN_W-1:0]      tempo_den;

    logic                  chan_mul;
    logic [RATIO_W-1:0]    chan_ratio;
    logic [INC_W-1:0]      chan_prod;

    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    logic [STEP_W-1:0]     div_steps;
    logic                  div_busy;
    logic [NUM_W-1:0]      div_quot;
    logic [PHASE_BITS-1:0] quot_c;

    logic [PHASE_BITS-1:0] l_ph [NUM_ACC];
    logic [SEL_W-1:0]      l_sel [NUM_CH];
    logic [SEL_W-1:0]      sel_c;

    logic [INC_W-1:0]      a_inc [NUM_ACC];
    logic [INC_W:0]        a_sum;
    logic [PHASE_BITS-1:0] a_ph [NUM_ACC];
    logic                  a_fire [NUM_ACC];
    logic [PLEN_W-1:0]     a_rem;
    logic [PLEFT_W-1:0]    a_pleft [NUM_ACC];
    logic [NUM_ACC-1:0]    a_gate;

    always_comb begin
        tempo_c = (r_tempo < BPM_MIN) ? BPM_MIN : ((r_tempo > BPM_MAX) ? BPM_MAX : r_tempo);
        sr_c    = (r_sr < SR_MIN) ? SR_MIN : ((r_sr > SR_MAX) ? SR_MAX : r_sr);
        plen_c  = (r_plen < PLEN_MIN) ? PLEN_MIN : ((r_plen > PLEN_MAX) ? PLEN_MAX : r_plen);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo    <= BPM_RST;
            r_sel[0]   <= SEL_RST;
            r_sel[1]   <= SEL_RST;
            r_sel[2]   <= SEL_RST;
            r_ppqn_sel <= PPQN_SEL_RST;
            r_sr       <= SR_RST;
            r_plen     <= PLEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEMPO:       r_tempo    <= i_cfg_data[BPM_W-1:0];
                CFG_RATIO_ONE:   r_sel[0]   <= i_cfg_data[SEL_W-1:0];
                CFG_RATIO_TWO:   r_sel[1]   <= i_cfg_data[SEL_W-1:0];
                CFG_RATIO_THREE: r_sel[2]   <= i_cfg_data[SEL_W-1:0];
                CFG_PPQN:        r_ppqn_sel <= i_cfg_data[PPQN_SEL_W-1:0];
                CFG_SAMPLE_RATE: r_sr       <= i_cfg_data[SR_W-1:0];
                CFG_PULSE_LEN:   r_plen     <= i_cfg_data[PLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end: edges, run latch and sync bookkeeping
    always_comb begin
        rst_edge     = r_item.reset_level & ~r_prev[0];
        tog_edge     = r_item.run_toggle_level & ~r_prev[1];
        clk_edge     = r_item.ext_clock_level & ~r_prev[2];
        run_latch_nx = r_run_latch ^ tog_edge;
        se_inc       = (r_since == SE_SAT) ? r_since : r_since + SE_W'(1);
        to_lim       = SE_W'(sr_c) * SE_W'(TIMEOUT_SECONDS);
        timed        = se_inc > to_lim;
        sync_div     = clk_edge & (r_warm >= WARM_DONE);
        need_div     = ~r_item.ext_connected | sync_div;
        sync_den     = DEN_W'(se_inc) * DEN_W'(ppqn_of(r_ppqn_sel));
        tempo_den    = DEN_W'(sr_c) * SEC_PER_MIN;
        if (!r_item.ext_connected) begin
            f_run = run_latch_nx;
        end else if (clk_edge) begin
            f_run = 1'b1;
        end else begin
            f_run = run_latch_nx & ~timed;
        end
    end

    always_comb begin
        chan_mul   = r_lsel[r_k] >= MUL_SEL_FIRST;
        chan_ratio = RATIO_TAB[r_lsel[r_k]];
        chan_prod  = INC_W'(r_sync_inc) * INC_W'(chan_ratio);
        quot_c     = (div_quot[PHASE_BITS-1:0] == '0) ? PHASE_BITS'(1)
                                                     : div_quot[PHASE_BITS-1:0];
    end

    always_comb begin
        div_start = (i_cmd.front & need_div) | (i_cmd.chan_eval & ~chan_mul);
        div_num   = {r_sync_inc, BPM_W'(0)};
        div_den   = DEN_W'(chan_ratio);
        div_steps = STEP_W'(PHASE_BITS);
        if (i_cmd.front) begin
            if (!r_item.ext_connected) begin
                div_num   = {tempo_c, PHASE_BITS'(0)};
                div_den   = tempo_den;
                div_steps = STEP_W'(NUM_W);
            end else begin
                div_num   = {1'b1, (NUM_W-1)'(0)};
                div_den   = sync_den;
                div_steps = STEP_W'(PHASE_BITS + 1);
            end
        end
    end

    tcrg_div #(
        .NUM_W  (NUM_W),
        .D_W    (DEN_W),
        .STEP_W (STEP_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // ratio latch chain, each channel gated by the phase before it
    always_comb begin
        for (int i = 0; i < NUM_ACC; i++) begin
            l_ph[i] = r_phase[i];
        end
        for (int i = 0; i < NUM_CH; i++) begin
            l_sel[i] = r_lsel[i];
        end
        for (int i = 0; i < NUM_CH; i++) begin
            sel_c = clamp_sel(r_sel[i]);
            if (l_sel[i] != sel_c && l_ph[i] == '0) begin
                l_sel[i]  = sel_c;
                l_ph[i+1] = '0;
            end
        end
    end

    // phase advance and gate pulses
    always_comb begin
        a_inc[0] = INC_W'(r_sync_inc);
        a_inc[1] = r_inc_ch[0];
        a_inc[2] = r_inc_ch[1];
        a_inc[3] = r_inc_ch[2];
        a_sum    = '0;
        a_rem    = '0;
        for (int i = 0; i < NUM_ACC; i++) begin
            a_sum = (INC_W+1)'(r_phase[i]) + (INC_W+1)'(a_inc[i]);
            if (!r_run || (a_sum[INC_W:PHASE_BITS] != '0)) begin
                a_ph[i] = '0;
            end else begin
                a_ph[i] = a_sum[PHASE_BITS-1:0];
            end
            a_fire[i] = r_run && (a_ph[i] == '0);
            a_rem     = {1'b0, r_pleft[i]};
            if (a_fire[i] && a_rem < plen_c) begin
                a_rem = plen_c;
            end
            a_gate[i]  = a_rem != '0;
            a_pleft[i] = (a_rem != '0) ? PLEFT_W'(a_rem - PLEN_W'(1)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_run_latch <= RUN_RST;
            r_since     <= '0;
            r_warm      <= '0;
            r_sync_inc  <= SYNC_INC_RST;
            r_run       <= 1'b0;
            r_k         <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_lsel[i] <= SEL_RST;
            end
            for (int i = 0; i < NUM_ACC; i++) begin
                r_phase[i] <= '0;
                r_pleft[i] <= '0;
            end
        end else begin
            if (i_cmd.front) begin
                r_prev      <= {r_item.ext_clock_level, r_item.run_toggle_level,
                                r_item.reset_level};
                r_run_latch <= run_latch_nx;
                r_run       <= f_run;
                if (rst_edge) begin
                    for (int i = 0; i < NUM_ACC; i++) begin
                        r_phase[i] <= '0;
                    end
                end
                if (!r_item.ext_connected) begin
                    r_since <= '0;
                    r_warm  <= '0;
                end else if (clk_edge) begin
                    r_since <= '0;
                    if (!sync_div) begin
                        r_warm <= r_warm + WARM_W'(1);
                    end
                end else begin
                    r_since <= se_inc;
                    if (timed) begin
                        r_warm <= '0;
                    end
                end
            end
            if (i_cmd.master_take) begin
                r_sync_inc <= quot_c;
            end
            if (i_cmd.latch) begin
                r_k <= '0;
                if (r_run) begin
                    for (int i = 0; i < NUM_ACC; i++) begin
                        r_phase[i] <= l_ph[i];
                    end
                    for (int i = 0; i < NUM_CH; i++) begin
                        r_lsel[i] <= l_sel[i];
                    end
                end
            end
            if ((i_cmd.chan_eval && chan_mul) || i_cmd.chan_take) begin
                r_k <= r_k + 2'd1;
            end
            if (i_cmd.advance) begin
                for (int i = 0; i < NUM_ACC; i++) begin
                    r_phase[i] <= a_ph[i];
                    r_pleft[i] <= a_pleft[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.chan_eval && chan_mul) begin
            r_inc_ch[r_k] <= chan_prod;
        end
        if (i_cmd.chan_take) begin
            r_inc_ch[r_k] <= INC_W'(quot_c);
        end
        if (i_cmd.advance) begin
            r_res.master_gate <= a_gate[0];
            r_res.gate_one    <= a_gate[1];
            r_res.gate_two    <= a_gate[2];
            r_res.gate_three  <= a_gate[3];
            r_res.running     <= r_run;
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.need_div  = need_div;
        o_sts.run       = r_run;
        o_sts.div_done  = ~div_busy;
        o_sts.chan_mul  = chan_mul;
        o_sts.chan_last = (r_k == 2'd2);
        o_sts.out_free  = ~r_out_valid | i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

[sv/tcrg_ctrl.sv]
// tcrg_ctrl.sv: controller state machine sequencing one item through the datapath
`default_nettype none
module tcrg_ctrl
    import tcrg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_FRONT;
            end
            S_FRONT: begin
                n_state = i_sts.need_div ? S_MDIV : S_LATCH;
            end
            S_MDIV: begin
                if (i_sts.div_done) n_state = S_LATCH;
            end
            S_LATCH: begin
                n_state = i_sts.run ? S_CHAN : S_ADVANCE;
            end
            S_CHAN: begin
                if (!i_sts.chan_mul) begin
                    n_state = S_CDIV;
                end else if (i_sts.chan_last) begin
                    n_state = S_ADVANCE;
                end
            end
            S_CDIV: begin
                if (i_sts.div_done) n_state = i_sts.chan_last ? S_ADVANCE : S_CHAN;
            end
            S_ADVANCE: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_FRONT:   o_cmd.front       = 1'b1;
            S_MDIV:    o_cmd.master_take = i_sts.div_done;
            S_LATCH:   o_cmd.latch       = 1'b1;
            S_CHAN:    o_cmd.chan_eval   = 1'b1;
            S_CDIV:    o_cmd.chan_take   = i_sts.div_done;
            S_ADVANCE: o_cmd.advance     = 1'b1;
            S_OUT:     o_cmd.out_load    = i_sts.out_free;
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/tempo_clock_ratio_gates.sv]
// tempo_clock_ratio_gates.sv: top level of the tempo clock with three ratio gate channels
//
// One input item is one sample tick; each item yields one result item with the
// master gate, three ratio gates and the running flag. Items are handled one at a
// time by a sequencer over a shared bit-serial divider. Each tick steps through the
// sequencer states, and the divider runs for the internal tempo increment (every tick
// in internal mode), on an external edge after warm-up, and while running for
// each dividing channel; a multiplying channel is multiplied without the divider.
// The result sits in an output register, so the next item is taken while it waits;
// a result still waiting when the next one is ready holds the sequencer.
`default_nettype none
module tempo_clock_ratio_gates
    import tcrg_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TIMEOUT_SECONDS = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data
);

    t_cmd cmd;
    t_sts sts;

    tcrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    tcrg_dp #(
        .PHASE_BITS      (PHASE_BITS),
        .TIMEOUT_SECONDS (TIMEOUT_SECONDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
